[rtl/xsf_pkg.sv]
// Shared types, codes and helpers of the x86 status-flag unit.
package xsf_pkg;

  localparam int unsigned NumFlags = 9;
  localparam int unsigned FlagIdxW = 4;
  localparam int unsigned WordW    = 16;

  // Flag indexes into the internal flag vector
  localparam logic [FlagIdxW-1:0] FB_CF = 4'd0;
  localparam logic [FlagIdxW-1:0] FB_PF = 4'd1;
  localparam logic [FlagIdxW-1:0] FB_AF = 4'd2;
  localparam logic [FlagIdxW-1:0] FB_ZF = 4'd3;
  localparam logic [FlagIdxW-1:0] FB_SF = 4'd4;
  localparam logic [FlagIdxW-1:0] FB_TF = 4'd5;
  localparam logic [FlagIdxW-1:0] FB_IF = 4'd6;
  localparam logic [FlagIdxW-1:0] FB_DF = 4'd7;
  localparam logic [FlagIdxW-1:0] FB_OF = 4'd8;

  typedef enum logic [2:0] {
    REQ_ARITH    = 3'd0,
    REQ_WR_WORD  = 3'd1,
    REQ_WR_SZAPC = 3'd2,
    REQ_SZP      = 3'd3,
    REQ_ONE_FLAG = 3'd4,
    REQ_READ     = 3'd5
  } req_type_e;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_ADC = 3'd1,
    OP_SUB = 3'd2,
    OP_SBB = 3'd3,
    OP_CMP = 3'd4
  } op_kind_e;

  typedef struct packed {
    logic [2:0]          req_type;
    logic [2:0]          op_kind;
    logic                wide;
    logic [WordW-1:0]    operand_a;
    logic [WordW-1:0]    operand_b;
    logic [WordW-1:0]    result_value;
    logic [5:0]          update_mask;
    logic [WordW-1:0]    flags_word;
    logic [FlagIdxW-1:0] flag_index;
    logic                flag_value;
  } req_t;

  // Place the flags at their x86 positions under the kept upper nibble
  function automatic logic [WordW-1:0] assemble(input logic [NumFlags-1:0] fl,
                                                input logic [3:0] nib);
    logic [WordW-1:0] w;
    w      = '0;
    w[15:12] = nib;
    w[11]  = fl[FB_OF];
    w[10]  = fl[FB_DF];
    w[9]   = fl[FB_IF];
    w[8]   = fl[FB_TF];
    w[7]   = fl[FB_SF];
    w[6]   = fl[FB_ZF];
    w[4]   = fl[FB_AF];
    w[2]   = fl[FB_PF];
    w[0]   = fl[FB_CF];
    return w;
  endfunction

endpackage

[rtl/xsf_if.sv]
// Valid/ready channels of the status-flag unit: request in, flags word out.
interface xsf_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [2:0]  op_kind;
  logic        wide;
  logic [15:0] operand_a;
  logic [15:0] operand_b;
  logic [15:0] result_value;
  logic [5:0]  update_mask;
  logic [15:0] flags_word;
  logic [3:0]  flag_index;
  logic        flag_value;

  modport source (output valid, req_type, op_kind, wide, operand_a, operand_b,
                  result_value, update_mask, flags_word, flag_index, flag_value,
                  input ready);
  modport sink   (input valid, req_type, op_kind, wide, operand_a, operand_b,
                  result_value, update_mask, flags_word, flag_index, flag_value,
                  output ready);
endinterface

interface xsf_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] flags_out;

  modport source (output valid, flags_out, input ready);
  modport sink   (input valid, flags_out, output ready);
endinterface

[rtl/xsf_flag_calc.sv]
// Next-state logic of the flag register for one request.
module xsf_flag_calc (
  input  xsf_pkg::req_t                        req_i,
  input  logic [xsf_pkg::NumFlags-1:0]         flags_i,
  input  logic [3:0]                           nibble_i,
  output logic [xsf_pkg::NumFlags-1:0]         flags_o,
  output logic [3:0]                           nibble_o
);

  logic [15:0] full;
  logic [15:0] a, b, r;
  logic        sa, sb, sr;
  logic        par_even;
  logic        cf, of, adder, known;

  always_comb begin
    full  = req_i.wide ? 16'hffff : 16'h00ff;
    a     = req_i.operand_a & full;
    b     = req_i.operand_b & full;
    r     = req_i.result_value & full;
    sa    = req_i.wide ? a[15] : a[7];
    sb    = req_i.wide ? b[15] : b[7];
    sr    = req_i.wide ? r[15] : r[7];
    par_even = ~(^r[7:0]);
    adder = (req_i.op_kind == xsf_pkg::OP_ADD) || (req_i.op_kind == xsf_pkg::OP_ADC);
    known = 1'b1;
    case (req_i.op_kind) inside
      xsf_pkg::OP_ADD: cf = (r < a) || (r < b);
      xsf_pkg::OP_ADC: cf = (r <= a);
      xsf_pkg::OP_SBB: cf = (a < r) || (b == full);
      xsf_pkg::OP_SUB, xsf_pkg::OP_CMP: cf = (a < b);
      default: begin
        cf    = 1'b0;
        known = 1'b0;
      end
    endcase
    of = adder ? ((sa == sb) && (sa != sr)) : ((sa != sb) && (sb == sr));
  end

  always_comb begin
    flags_o  = flags_i;
    nibble_o = nibble_i;
    unique case (req_i.req_type)
      xsf_pkg::REQ_ARITH: begin
        if (known) begin
          if (req_i.update_mask[0]) flags_o[xsf_pkg::FB_CF] = cf;
          if (req_i.update_mask[1]) flags_o[xsf_pkg::FB_PF] = par_even;
          if (req_i.update_mask[2]) flags_o[xsf_pkg::FB_AF] = a[4] ^ b[4] ^ r[4];
          if (req_i.update_mask[3]) flags_o[xsf_pkg::FB_ZF] = (r == 16'h0000);
          if (req_i.update_mask[4]) flags_o[xsf_pkg::FB_SF] = sr;
          if (req_i.update_mask[5]) flags_o[xsf_pkg::FB_OF] = of;
        end
      end
      xsf_pkg::REQ_WR_WORD: begin
        flags_o[xsf_pkg::FB_CF] = req_i.flags_word[0];
        flags_o[xsf_pkg::FB_PF] = req_i.flags_word[2];
        flags_o[xsf_pkg::FB_AF] = req_i.flags_word[4];
        flags_o[xsf_pkg::FB_ZF] = req_i.flags_word[6];
        flags_o[xsf_pkg::FB_SF] = req_i.flags_word[7];
        flags_o[xsf_pkg::FB_TF] = req_i.flags_word[8];
        flags_o[xsf_pkg::FB_IF] = req_i.flags_word[9];
        flags_o[xsf_pkg::FB_DF] = req_i.flags_word[10];
        flags_o[xsf_pkg::FB_OF] = req_i.flags_word[11];
        nibble_o = req_i.flags_word[15:12];
      end
      xsf_pkg::REQ_WR_SZAPC: begin
        flags_o[xsf_pkg::FB_SF] = req_i.flags_word[7];
        flags_o[xsf_pkg::FB_ZF] = req_i.flags_word[6];
        flags_o[xsf_pkg::FB_AF] = req_i.flags_word[4];
        flags_o[xsf_pkg::FB_PF] = req_i.flags_word[2];
        flags_o[xsf_pkg::FB_CF] = req_i.flags_word[0];
      end
      xsf_pkg::REQ_SZP: begin
        flags_o[xsf_pkg::FB_SF] = sr;
        flags_o[xsf_pkg::FB_ZF] = (r == 16'h0000);
        flags_o[xsf_pkg::FB_PF] = par_even;
      end
      xsf_pkg::REQ_ONE_FLAG: begin
        // Indexes past the overflow flag change nothing
        if (req_i.flag_index <= xsf_pkg::FB_OF) flags_o[req_i.flag_index] = req_i.flag_value;
      end
      default: begin
        flags_o  = flags_i;
      end
    endcase
  end

endmodule

[rtl/x86_status_flags_unit_top.sv]
// A request accepted into the input register shows its flags word from the result register.
// Throughput: one request per cycle while the result is not stalled; the flag state is written once per request
// as it leaves the input register, so the next request already sees it.
// A stalled result holds a full input register and the flag state.
// Reset clears all flags, the upper nibble and both valid bits.
module x86_status_flags_unit_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  xsf_req_if.sink    req_i,
  xsf_rsp_if.source  rsp_o
);

  logic                          s1_valid_q;
  xsf_pkg::req_t                 s1_req_q;
  xsf_pkg::req_t                 in_req;
  logic                          out_valid_q;
  logic [15:0]                   flags_out_q;
  logic [xsf_pkg::NumFlags-1:0]  flag_bits_q, flag_bits_d;
  logic [3:0]                    nibble_q, nibble_d;
  logic                          advance;
  logic                          fire;

  assign in_req = '{req_type:     req_i.req_type,
                    op_kind:      req_i.op_kind,
                    wide:         req_i.wide,
                    operand_a:    req_i.operand_a,
                    operand_b:    req_i.operand_b,
                    result_value: req_i.result_value,
                    update_mask:  req_i.update_mask,
                    flags_word:   req_i.flags_word,
                    flag_index:   req_i.flag_index,
                    flag_value:   req_i.flag_value};

  // The input register moves on whenever the result register is free or drained
  assign advance     = !out_valid_q || rsp_o.ready;
  assign fire        = s1_valid_q && advance;
  assign req_i.ready = !s1_valid_q || advance;

  xsf_flag_calc u_calc (
    .req_i    (s1_req_q),
    .flags_i  (flag_bits_q),
    .nibble_i (nibble_q),
    .flags_o  (flag_bits_d),
    .nibble_o (nibble_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flag_bits_q <= '0;
      nibble_q    <= '0;
    end else begin
      if (req_i.ready) s1_valid_q <= req_i.valid;
      if (advance) out_valid_q <= s1_valid_q;
      if (fire) begin
        flag_bits_q <= flag_bits_d;
        nibble_q    <= nibble_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) s1_req_q <= in_req;
    if (fire) flags_out_q <= xsf_pkg::assemble(flag_bits_d, nibble_d);
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.flags_out = flags_out_q;

`ifndef SYNTHESIS
  // A stalled result freezes the flag state
  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |=> ($stable(flag_bits_q) && $stable(nibble_q)))
    else $error("flag state changed while the result was stalled");

  // The upper nibble moves only on a whole-word write
  a_nibble_only_on_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(nibble_q) |-> $past(fire && (s1_req_q.req_type == xsf_pkg::REQ_WR_WORD)))
    else $error("upper nibble changed without a word write");

  // A result beat carries the flag state left by its own request
  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (out_valid_q && flags_out_q == xsf_pkg::assemble(flag_bits_q, nibble_q)))
    else $error("result word does not match the flag state");

  // Reserved bits of the flags word stay clear
  a_reserved_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!flags_out_q[5] && !flags_out_q[3] && !flags_out_q[1]))
    else $error("reserved flag bit set in result");
`endif

endmodule
